FILE: rtl/core/kes_pkg.sv
package kes_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_TAG_BITS    = 16;
    localparam int KEY_BITS        = 64;
    localparam int PAY_BITS        = 64;
    localparam int TAG_PORT_BITS   = 16;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic wr_in;      // write the incoming record
        logic wr_held;    // write the held record back
        logic load_held;  // take the read data into the held record
        logic cmp_en;     // compare held against read data, exchange if greater
        logic load_out;   // take the read data into the output register
    } kes_cmd_t;

    // Numeric a > b on binary64 patterns; NaN compares false, -0 equals +0
    function automatic logic fp_gt(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan     = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan || both_zero)
        begin
            res = 1'b0;
        end
        else if (a[63] != b[63])
        begin
            res = b[63];
        end
        else if (a[63] == 1'b0)
        begin
            res = a[62:0] > b[62:0];
        end
        else
        begin
            res = a[62:0] < b[62:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/kes_datapath.sv
module kes_datapath
    import kes_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int AW         = $clog2(MAX_ENTRIES)
)
(
    input  logic                     clk,
    input  kes_cmd_t                 cmd,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic [KEY_BITS-1:0]      sort_key,
    input  logic [PAY_BITS-1:0]      payload_first,
    input  logic [PAY_BITS-1:0]      payload_second,
    input  logic [TAG_PORT_BITS-1:0] record_tag,
    output logic [KEY_BITS-1:0]      out_key,
    output logic [PAY_BITS-1:0]      out_first,
    output logic [PAY_BITS-1:0]      out_second,
    output logic [TAG_PORT_BITS-1:0] out_tag
);

    logic [KEY_BITS-1:0] key_mem    [MAX_ENTRIES];
    logic [PAY_BITS-1:0] first_mem  [MAX_ENTRIES];
    logic [PAY_BITS-1:0] second_mem [MAX_ENTRIES];
    logic [TAG_BITS-1:0] tag_mem    [MAX_ENTRIES];

    logic [KEY_BITS-1:0] rd_key_reg;
    logic [PAY_BITS-1:0] rd_first_reg;
    logic [PAY_BITS-1:0] rd_second_reg;
    logic [TAG_BITS-1:0] rd_tag_reg;

    logic [KEY_BITS-1:0] held_key_reg;
    logic [PAY_BITS-1:0] held_first_reg;
    logic [PAY_BITS-1:0] held_second_reg;
    logic [TAG_BITS-1:0] held_tag_reg;

    logic [KEY_BITS-1:0] out_key_reg;
    logic [PAY_BITS-1:0] out_first_reg;
    logic [PAY_BITS-1:0] out_second_reg;
    logic [TAG_BITS-1:0] out_tag_reg;

    logic                swap;
    logic                wr_en;

    assign swap  = cmd.cmp_en && fp_gt(held_key_reg, rd_key_reg);
    assign wr_en = cmd.wr_in || cmd.wr_held || swap;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (cmd.wr_in)
            begin
                key_mem[wr_addr]    <= sort_key;
                first_mem[wr_addr]  <= payload_first;
                second_mem[wr_addr] <= payload_second;
                tag_mem[wr_addr]    <= TAG_BITS'(record_tag);
            end
            else
            begin
                key_mem[wr_addr]    <= held_key_reg;
                first_mem[wr_addr]  <= held_first_reg;
                second_mem[wr_addr] <= held_second_reg;
                tag_mem[wr_addr]    <= held_tag_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg    <= key_mem[rd_addr];
        rd_first_reg  <= first_mem[rd_addr];
        rd_second_reg <= second_mem[rd_addr];
        rd_tag_reg    <= tag_mem[rd_addr];
    end

    // take the smaller record into the held slot on an exchange
    always_ff @(posedge clk)
    begin
        if (cmd.load_held || swap)
        begin
            held_key_reg    <= rd_key_reg;
            held_first_reg  <= rd_first_reg;
            held_second_reg <= rd_second_reg;
            held_tag_reg    <= rd_tag_reg;
        end
        if (cmd.load_out)
        begin
            out_key_reg    <= rd_key_reg;
            out_first_reg  <= rd_first_reg;
            out_second_reg <= rd_second_reg;
            out_tag_reg    <= rd_tag_reg;
        end
    end

    assign out_key    = out_key_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_tag    = TAG_PORT_BITS'(out_tag_reg);

endmodule

FILE: rtl/core/kes_ctrl.sv
module kes_ctrl
    import kes_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int AW         = $clog2(MAX_ENTRIES),
    localparam int CW         = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          set_end,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_final,
    output logic          dropped_flag,
    output kes_cmd_t      cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_IRD,
        S_HOLD,
        S_CMP,
        S_WRI,
        S_ERD,
        S_ELD
    } state_t;

    localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

    state_t        state_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] k_reg;
    logic          ovf_reg;
    logic          set_ovf_reg;
    logic          out_valid_reg;
    logic          out_final_reg;
    logic          dropped_reg;

    logic          in_acc;
    logic          full;
    logic          out_free;
    logic [CW-1:0] n_last;

    assign in_acc   = in_valid && (state_reg == S_LOAD);
    assign full     = (fill_reg == FULL);
    assign out_free = !out_valid_reg || out_ready;
    assign n_last   = n_reg - CW'(1);

    always_comb
    begin
        cmd     = '0;
        rd_addr = i_reg[AW-1:0];
        wr_addr = fill_reg[AW-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.wr_in = in_acc && !full;
            end
            S_IRD:
            begin
                rd_addr = i_reg[AW-1:0];
            end
            S_HOLD:
            begin
                cmd.load_held = 1'b1;
                rd_addr       = j_reg[AW-1:0];
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                rd_addr    = AW'(j_reg + CW'(1));
            end
            S_WRI:
            begin
                cmd.wr_held = 1'b1;
                wr_addr     = i_reg[AW-1:0];
            end
            S_ERD:
            begin
                rd_addr = k_reg[AW-1:0];
            end
            S_ELD:
            begin
                // keep reading the same record while the output is blocked
                rd_addr      = k_reg[AW-1:0];
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            set_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_final_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !((state_reg == S_ELD) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (set_end)
                        begin
                            n_reg       <= full ? fill_reg : fill_reg + CW'(1);
                            set_ovf_reg <= ovf_reg || full;
                            fill_reg    <= '0;
                            ovf_reg     <= 1'b0;
                            i_reg       <= '0;
                            state_reg   <= S_IRD;
                        end
                        else if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                    end
                end
                S_IRD:
                begin
                    if (i_reg >= n_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        j_reg     <= i_reg + CW'(1);
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (j_reg == n_last)
                    begin
                        state_reg <= S_WRI;
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                S_WRI:
                begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_IRD;
                end
                S_ERD:
                begin
                    state_reg <= S_ELD;
                end
                S_ELD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_final_reg <= (k_reg == n_last);
                        dropped_reg   <= set_ovf_reg;
                        if (k_reg == n_last)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_LOAD);
    assign out_valid    = out_valid_reg;
    assign out_final    = out_final_reg;
    assign dropped_flag = dropped_reg;

endmodule

FILE: rtl/core/keyed_exchange_sort.sv
// Keyed exchange sort. Records (binary64 key, two 64-bit payloads, tag) are
// loaded one per cycle while in_ready is high, one per input transfer; the
// transfer with set_end high closes the set. Records arriving once
// MAX_ENTRIES are held are dropped and dropped_flag is raised on every result
// of that set. The set is then sorted ascending by key as IEEE doubles (NaN
// never moves, -0 equals +0) using the classic exchange order, and emitted
// with out_final on the last record. The sort makes one key compare per
// cycle against a record memory with one read and one write port, with the
// record at position i held in a register while j sweeps; emission then
// reads each record from memory and loads it into the output register. No
// input is taken from the close of a set until its final result is loaded
// into the output register; the last result may still wait there while the
// next set loads.
module keyed_exchange_sort
    import kes_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TAG_BITS    = DEF_TAG_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KEY_BITS-1:0]      sort_key,
    input  logic [PAY_BITS-1:0]      payload_first,
    input  logic [PAY_BITS-1:0]      payload_second,
    input  logic [TAG_PORT_BITS-1:0] record_tag,
    input  logic                     set_end,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [KEY_BITS-1:0]      out_key,
    output logic [PAY_BITS-1:0]      out_first,
    output logic [PAY_BITS-1:0]      out_second,
    output logic [TAG_PORT_BITS-1:0] out_tag,
    output logic                     out_final,
    output logic                     dropped_flag
);

    localparam int AW = $clog2(MAX_ENTRIES);

    kes_cmd_t      cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // sequencing: load, sort passes, emission
    kes_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .set_end     (set_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_final   (out_final),
        .dropped_flag(dropped_flag),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr)
    );

    // record memory, held record, key compare and output register
    kes_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .sort_key      (sort_key),
        .payload_first (payload_first),
        .payload_second(payload_second),
        .record_tag    (record_tag),
        .out_key       (out_key),
        .out_first     (out_first),
        .out_second    (out_second),
        .out_tag       (out_tag)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kes_pkg::*;

    localparam int CAPACITY  = DEF_MAX_ENTRIES;
    localparam int TAG_KEEP  = DEF_TAG_BITS;
    // Longest quiet spell: a full 64-record sort plus long receiver hold-offs
    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        logic [KEY_BITS-1:0]      key;
        logic [PAY_BITS-1:0]      first;
        logic [PAY_BITS-1:0]      second;
        logic [TAG_PORT_BITS-1:0] tag;
        logic                     final_rec;
        logic                     dropped;
    } sorted_rec_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [KEY_BITS-1:0]      sort_key;
    logic [PAY_BITS-1:0]      payload_first;
    logic [PAY_BITS-1:0]      payload_second;
    logic [TAG_PORT_BITS-1:0] record_tag;
    logic                     set_end;
    logic                     out_valid;
    logic                     out_ready;
    logic [KEY_BITS-1:0]      out_key;
    logic [PAY_BITS-1:0]      out_first;
    logic [PAY_BITS-1:0]      out_second;
    logic [TAG_PORT_BITS-1:0] out_tag;
    logic                     out_final;
    logic                     dropped_flag;

    // Predictor state: records of the set being collected
    logic [KEY_BITS-1:0]      held_key[CAPACITY];
    logic [PAY_BITS-1:0]      held_first[CAPACITY];
    logic [PAY_BITS-1:0]      held_second[CAPACITY];
    logic [TAG_PORT_BITS-1:0] held_tag[CAPACITY];
    int                       held_count;
    logic                     overflow_hit;

    sorted_rec_t sorted_queue[$];
    int          error_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;

    keyed_exchange_sort DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sort_key       (sort_key),
        .payload_first  (payload_first),
        .payload_second (payload_second),
        .record_tag     (record_tag),
        .set_end        (set_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_key        (out_key),
        .out_first      (out_first),
        .out_second     (out_second),
        .out_tag        (out_tag),
        .out_final      (out_final),
        .dropped_flag   (dropped_flag)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Numeric a > b on binary64 patterns, written independently: NaN never
    // compares greater and the two zeros are equal.
    function automatic bit key_greater(input logic [63:0] a, input logic [63:0] b);
        bit a_nan;
        bit b_nan;
        bit res;
        a_nan = (&a[62:52]) && (|a[51:0]);
        b_nan = (&b[62:52]) && (|b[51:0]);
        if (a_nan || b_nan)
            res = 1'b0;
        else if (a[62:0] == 63'd0 && b[62:0] == 63'd0)
            res = 1'b0;
        else if (!a[63] && !b[63])
            res = a[62:0] > b[62:0];
        else if (a[63] && b[63])
            res = a[62:0] < b[62:0];
        else
            res = b[63];
        return res;
    endfunction

    // Store one record, or note an overflow when the store is full; on the end
    // of the set sort in exchange order and queue every sorted record.
    task automatic predict_record(input logic [63:0] k, input logic [63:0] p1,
                                  input logic [63:0] p2, input logic [15:0] t,
                                  input logic e);
        logic [63:0]  tk;
        logic [63:0]  tf;
        logic [63:0]  ts;
        logic [15:0]  tt;
        sorted_rec_t  r;
        if (held_count < CAPACITY)
        begin
            held_key[held_count]    = k;
            held_first[held_count]  = p1;
            held_second[held_count] = p2;
            held_tag[held_count]    = TAG_PORT_BITS'(t & ((1 << TAG_KEEP) - 1));
            held_count++;
        end
        else
            overflow_hit = 1'b1;
        if (e)
        begin
            for (int i = 0; i < held_count; i++)
                for (int j = i + 1; j < held_count; j++)
                    if (key_greater(held_key[i], held_key[j]))
                    begin
                        tk = held_key[i];    held_key[i]    = held_key[j];    held_key[j]    = tk;
                        tf = held_first[i];  held_first[i]  = held_first[j];  held_first[j]  = tf;
                        ts = held_second[i]; held_second[i] = held_second[j]; held_second[j] = ts;
                        tt = held_tag[i];    held_tag[i]    = held_tag[j];    held_tag[j]    = tt;
                    end
            for (int i = 0; i < held_count; i++)
            begin
                r.key       = held_key[i];
                r.first     = held_first[i];
                r.second    = held_second[i];
                r.tag       = held_tag[i];
                r.final_rec = (i == held_count - 1);
                r.dropped   = overflow_hit;
                sorted_queue = {sorted_queue, r};
            end
            held_count   = 0;
            overflow_hit = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one record, idling first at the current rate; hold until transfer.
    // Valid stays high afterwards so records can follow back to back.
    task automatic send_record(input logic [63:0] k, input logic [63:0] p1,
                               input logic [63:0] p2, input logic [15:0] t,
                               input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        sort_key       <= k;
        payload_first  <= p1;
        payload_second <= p2;
        record_tag     <= t;
        set_end        <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_record(k, p1, p2, t, e);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sorted_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int pick;
        k = {$urandom, $urandom};
        pick = $urandom_range(9);
        // Favour collisions, zeros, infinities and NaNs among ordinary values
        case (pick)
            0: k = {1'($urandom_range(1)), 63'd0};
            1: k = {1'($urandom_range(1)), 11'h7FF, 52'd0};
            2: k = {1'($urandom_range(1)), 11'h7FF, 20'd0, $urandom | 32'd1};
            3: k = {1'($urandom_range(1)), 11'h3FF, 50'd0, 2'($urandom)};
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_random_set(input int n);
        for (int i = 0; i < n; i++)
            send_record(random_key(), {$urandom, $urandom}, {$urandom, $urandom},
                        16'($urandom), i == n - 1);
    endtask

    // Extremes of every field, both zeros, infinities, NaNs and equal keys
    task automatic test_directed();
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'hFFFF, 1'b0);
        send_record(64'h8000_0000_0000_0000, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);
        send_record(64'h0000_0000_0000_0000, 64'h1, 64'h2, 16'h0001, 1'b0);
        send_record(64'h7FF0_0000_0000_0000, 64'h3, 64'h4, 16'h8000, 1'b0);
        send_record(64'hFFF0_0000_0000_0000, 64'h5, 64'h6, 16'h1234, 1'b0);
        send_record(64'h7FF8_0000_0000_0001, 64'h7, 64'h8, 16'h4321, 1'b0);
        send_record(64'h3FF0_0000_0000_0000, 64'h9, 64'hA, 16'hAAAA, 1'b0);
        send_record(64'h3FF0_0000_0000_0000, 64'hB, 64'hC, 16'h5555, 1'b0);
        send_record(64'hBFF0_0000_0000_0000, 64'hD, 64'hE, 16'h00FF, 1'b0);
        send_record(64'h0000_0000_0000_0001, 64'hF, 64'h10, 16'hFF00, 1'b0);
        send_record(64'h7FEF_FFFF_FFFF_FFFF, 64'h11, 64'h12, 16'h0F0F, 1'b1);
        // Single-record set, then a zero pair, -0 followed by +0
        send_record(64'h4000_0000_0000_0000, 64'h13, 64'h14, 16'h00AA, 1'b1);
        send_record(64'h8000_0000_0000_0000, 64'h15, 64'h16, 16'h0002, 1'b0);
        send_record(64'h0000_0000_0000_0000, 64'h17, 64'h18, 16'h0003, 1'b1);
        drain_results();
    endtask

    // Overfill the store so the final records, set_end among them, are dropped
    task automatic test_overflow();
        send_random_set(CAPACITY + 2);
        drain_results();
    endtask

    // Hold the receiver off while records keep coming, so input stalls
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                send_random_set(3);
                send_random_set(4);
            end
            begin
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
        join
        drain_results();
    endtask

    task automatic test_random_sets(input int sender_pct, input int receiver_pct,
                                    input int budget);
        int sent;
        int n;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < budget)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 8);
            send_random_set(n);
            sent += n;
        end
        drain_results();
    endtask

    // Receiver: idle at the current rate, hold off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result transfer against the oldest sorted record
    always @(posedge clk)
    begin
        sorted_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_queue.size() == 0)
                report_mismatch("unexpected result key", out_key, 64'd0);
            else
            begin
                want = sorted_queue.pop_front();
                if (out_key !== want.key)
                    report_mismatch("out_key", out_key, want.key);
                if (out_first !== want.first)
                    report_mismatch("out_first", out_first, want.first);
                if (out_second !== want.second)
                    report_mismatch("out_second", out_second, want.second);
                if (out_tag !== want.tag)
                    report_mismatch("out_tag", 64'(out_tag), 64'(want.tag));
                if (out_final !== want.final_rec)
                    report_mismatch("out_final", 64'(out_final), 64'(want.final_rec));
                if (dropped_flag !== want.dropped)
                    report_mismatch("dropped_flag", 64'(dropped_flag), 64'(want.dropped));
            end
        end
    end

    // Watchdog: advance the quiet count on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sort_key       = '0;
        payload_first  = '0;
        payload_second = '0;
        record_tag     = '0;
        set_end        = 1'b0;
        held_count     = 0;
        overflow_hit   = 1'b0;
        error_count    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 66;
        recv_hold      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_sets(21, 66, 25);
        test_random_sets(66, 21, 25);
        test_random_sets(0, 0, 20);
        test_overflow();

        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: keyed_exchange_sort.f
rtl/core/kes_pkg.sv
rtl/core/kes_datapath.sv
rtl/core/kes_ctrl.sv
rtl/core/keyed_exchange_sort.sv
dv/testbench.sv
